### hdl/bmp_pixel_to_framebuffer_unit_macros.svh
// ----------------------------------------------------------------------------
// BMP blit assertion macros
// Shared concurrent assertion forms for the BMP-to-framebuffer blit unit.
// ----------------------------------------------------------------------------
`ifndef BMP_PIXEL_TO_FRAMEBUFFER_UNIT_MACROS_SVH
`define BMP_PIXEL_TO_FRAMEBUFFER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BMP2FB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BMP2FB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bmp2fb_pkg.sv
// ----------------------------------------------------------------------------
// BMP blit package
// Shared types, register indexes and helpers for the BMP-to-framebuffer blit.
// ----------------------------------------------------------------------------
package bmp2fb_pkg;

  // Largest image or screen dimension; larger register writes saturate
  localparam int MAX_DIM = 2048;

  localparam int DIM_W   = 12;
  localparam int IDX_W   = 22;
  localparam int WORD_W  = 24;
  localparam int CFG_A_W = 3;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_BOTTOM_UP        = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_FOUR_BYTE_PIXELS = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_SCREEN_WIDTH     = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_SCREEN_HEIGHT    = 3'd5;

  // Byte position inside a pixel
  localparam logic [1:0] BIP_BLUE  = 2'd0;
  localparam logic [1:0] BIP_GREEN = 2'd1;
  localparam logic [1:0] BIP_RED   = 2'd2;
  localparam logic [1:0] BIP_ALPHA = 2'd3;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 12'd1;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 12'd1;
  localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 12'd800;
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 12'd480;

  typedef struct packed {
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
    logic             bottom_up;
    logic             four_byte;
    logic [DIM_W-1:0] scr_w;
    logic [DIM_W-1:0] scr_h;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [WORD_W-1:0] word;
  } pix_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    clamp_dim = (32'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

### hdl/bmp2fb_cfg.sv
// ----------------------------------------------------------------------------
// BMP blit configuration registers
// Holds the image and screen setup; sizes are saturated when written.
// ----------------------------------------------------------------------------
module bmp2fb_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmp2fb_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [bmp2fb_pkg::DIM_W-1:0]     cfg_data,
  output bmp2fb_pkg::cfg_t                 cfg
);

  bmp2fb_pkg::cfg_t cfg_r;
  logic             wr;

  // Accept a write every cycle
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Update the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_w     <= bmp2fb_pkg::RST_IMAGE_WIDTH;
      cfg_r.img_h     <= bmp2fb_pkg::RST_IMAGE_HEIGHT;
      cfg_r.bottom_up <= 1'b1;
      cfg_r.four_byte <= 1'b0;
      cfg_r.scr_w     <= bmp2fb_pkg::RST_SCREEN_WIDTH;
      cfg_r.scr_h     <= bmp2fb_pkg::RST_SCREEN_HEIGHT;
    end else if (wr) begin
      case (cfg_index)
        bmp2fb_pkg::CFG_IMAGE_WIDTH:      cfg_r.img_w <= bmp2fb_pkg::clamp_dim(cfg_data);
        bmp2fb_pkg::CFG_IMAGE_HEIGHT:     cfg_r.img_h <= bmp2fb_pkg::clamp_dim(cfg_data);
        bmp2fb_pkg::CFG_BOTTOM_UP:        cfg_r.bottom_up <= cfg_data[0];
        bmp2fb_pkg::CFG_FOUR_BYTE_PIXELS: cfg_r.four_byte <= cfg_data[0];
        bmp2fb_pkg::CFG_SCREEN_WIDTH:     cfg_r.scr_w <= bmp2fb_pkg::clamp_dim(cfg_data);
        bmp2fb_pkg::CFG_SCREEN_HEIGHT:    cfg_r.scr_h <= bmp2fb_pkg::clamp_dim(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/bmp2fb_scan.sv
// ----------------------------------------------------------------------------
// BMP blit byte scanner
// Tracks row, column and byte position, skips row padding, gathers pixels.
// ----------------------------------------------------------------------------
`include "bmp_pixel_to_framebuffer_unit_macros.svh"

module bmp2fb_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  bmp2fb_pkg::cfg_t   cfg,
  input  logic               beat,
  input  logic [7:0]         pixel_byte,
  output logic               emit,
  output bmp2fb_pkg::pix_t   pix
);

  localparam int DW = bmp2fb_pkg::DIM_W;

  logic [DW-1:0] column_r, column_nxt;
  logic [DW-1:0] file_row_r, file_row_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [7:0]    blue_r, blue_nxt;
  logic [7:0]    green_r, green_nxt;

  logic          done;
  logic [DW-1:0] row_y;

  // Image finished (or empty): ignore every byte
  assign done  = (cfg.img_w == '0) || (cfg.img_h == '0) || (file_row_r >= cfg.img_h);
  assign row_y = cfg.bottom_up ? (cfg.img_h - DW'(1) - file_row_r) : file_row_r;

  // Next-state logic for one byte
  always_comb begin
    logic [DW-1:0] col_inc;
    logic [1:0]    pad_new;
    logic          finish;
    col_inc      = column_r + DW'(1);
    pad_new      = cfg.four_byte ? 2'd0 : cfg.img_w[1:0];
    finish       = 1'b0;
    column_nxt   = column_r;
    file_row_nxt = file_row_r;
    bip_nxt      = bip_r;
    pad_nxt      = pad_r;
    blue_nxt     = blue_r;
    green_nxt    = green_r;
    emit         = 1'b0;
    pix.row      = row_y;
    pix.col      = column_r;
    pix.word     = {pixel_byte, green_r, blue_r};

    if (beat && !done) begin
      if (pad_r != 2'd0) begin
        // Drop a padding byte; the last one closes the row
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) begin
          file_row_nxt = file_row_r + DW'(1);
          column_nxt   = '0;
          bip_nxt      = bmp2fb_pkg::BIP_BLUE;
        end
      end else begin
        case (bip_r)
          bmp2fb_pkg::BIP_BLUE: begin
            blue_nxt = pixel_byte;
            bip_nxt  = bmp2fb_pkg::BIP_GREEN;
          end
          bmp2fb_pkg::BIP_GREEN: begin
            green_nxt = pixel_byte;
            bip_nxt   = bmp2fb_pkg::BIP_RED;
          end
          bmp2fb_pkg::BIP_RED: begin
            emit = (column_r < cfg.scr_w) && (row_y < cfg.scr_h);
            if (cfg.four_byte) begin
              bip_nxt = bmp2fb_pkg::BIP_ALPHA;
            end else begin
              finish = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase

        // Close the pixel; at row end either start padding or the next row
        if (finish) begin
          bip_nxt    = bmp2fb_pkg::BIP_BLUE;
          column_nxt = col_inc;
          if (col_inc >= cfg.img_w) begin
            if (pad_new == 2'd0) begin
              file_row_nxt = file_row_r + DW'(1);
              column_nxt   = '0;
            end else begin
              pad_nxt = pad_new;
            end
          end
        end
      end
    end
  end

  // Counter and byte hold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      file_row_r <= '0;
      bip_r      <= bmp2fb_pkg::BIP_BLUE;
      pad_r      <= '0;
      blue_r     <= '0;
      green_r    <= '0;
    end else begin
      column_r   <= column_nxt;
      file_row_r <= file_row_nxt;
      bip_r      <= bip_nxt;
      pad_r      <= pad_nxt;
      blue_r     <= blue_nxt;
      green_r    <= green_nxt;
    end
  end

  `BMP2FB_ASSERT_NOW(a_pad_at_pixel_start, clk, rst_n, pad_r != 2'd0, bip_r == bmp2fb_pkg::BIP_BLUE, "padding started mid-pixel")
  `BMP2FB_ASSERT_NOW(a_no_pixel_after_image, clk, rst_n, beat && done, !emit, "pixel emitted after last row")

endmodule

### hdl/bmp2fb_out.sv
// ----------------------------------------------------------------------------
// BMP blit output stage
// Registers a gathered pixel, forms the framebuffer index, holds the result.
// ----------------------------------------------------------------------------
`include "bmp_pixel_to_framebuffer_unit_macros.svh"

module bmp2fb_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bmp2fb_pkg::DIM_W-1:0]      scr_w,
  input  logic                              load,
  input  bmp2fb_pkg::pix_t                  pix,
  output logic                              stall_up,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmp2fb_pkg::IDX_W-1:0]      out_fb_index,
  output logic [bmp2fb_pkg::WORD_W-1:0]     out_pixel_word
);

  localparam int DW   = bmp2fb_pkg::DIM_W;
  localparam int IW   = bmp2fb_pkg::IDX_W;
  localparam int PW   = 2 * DW;

  logic                          p1_valid_r;
  bmp2fb_pkg::pix_t              p1_r;
  logic                          out_valid_r;
  logic [IW-1:0]                 fb_index_r, fb_index_nxt;
  logic [bmp2fb_pkg::WORD_W-1:0] word_r;
  logic                          adv;
  logic [IW-1:0]                 sum;

  // Result register frees when empty or taken
  assign adv      = !out_valid_r || !out_stall;
  assign stall_up = p1_valid_r && !adv;

  // Row base plus column, kept to the index width
  assign sum          = IW'(PW'(p1_r.row) * PW'(scr_w)) + IW'(p1_r.col);
  assign fb_index_nxt = sum;

  // Pixel stage and result stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!stall_up) begin
        p1_valid_r <= load;
      end
      if (adv) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (!stall_up && load) begin
      p1_r <= pix;
    end
    if (adv && p1_valid_r) begin
      fb_index_r <= fb_index_nxt;
      word_r     <= p1_r.word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fb_index   = fb_index_r;
  assign out_pixel_word = word_r;

  `BMP2FB_ASSERT_NOW(a_stall_source, clk, rst_n, stall_up, out_valid_r && out_stall,
                     "upstream stalled without a held result")
  `BMP2FB_ASSERT_NEXT(a_pixel_moves, clk, rst_n, p1_valid_r && adv, out_valid_r,
                      "pixel lost between stages")

endmodule

### hdl/bmp_pixel_to_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// BMP pixel array to framebuffer blit
// Turns a 24/32-bit BMP pixel byte stream into framebuffer index/pixel beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_pixel_byte) carries the BMP pixel
//   array one byte per beat in file order, row padding included.
//   Output channel (out_valid/out_stall) carries one beat per visible pixel:
//   out_fb_index = screen row * screen width + column, out_pixel_word = RGB.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets image and
//   screen size, orientation and pixel size; write it while the unit is idle.
//   Throughput is one byte per cycle while in_stall is low; the byte that
//   completes a pixel passes the pixel register, then the index register
//   (one 12x12 multiply plus add), before its beat appears.
//   Reset clears the row/column counters and loads defaults: 1x1 bottom-up
//   24-bit image, 800x480 screen. Bytes after the last image row are dropped
//   until the next reset.
//   When out_stall holds the result register, the pixel register fills and
//   in_stall rises; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "bmp_pixel_to_framebuffer_unit_macros.svh"

module bmp_pixel_to_framebuffer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_pixel_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmp2fb_pkg::IDX_W-1:0]      out_fb_index,
  output logic [bmp2fb_pkg::WORD_W-1:0]     out_pixel_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmp2fb_pkg::CFG_A_W-1:0]    cfg_index,
  input  logic [bmp2fb_pkg::DIM_W-1:0]      cfg_data
);

  bmp2fb_pkg::cfg_t cfg;
  bmp2fb_pkg::pix_t pix;
  logic             beat;
  logic             emit;

  assign beat = in_valid && !in_stall;

  // Configuration registers
  bmp2fb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Byte scanner
  bmp2fb_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .beat       (beat),
    .pixel_byte (in_pixel_byte),
    .emit       (emit),
    .pix        (pix)
  );

  // Index and result stage
  bmp2fb_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .scr_w          (cfg.scr_w),
    .load           (emit),
    .pix            (pix),
    .stall_up       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fb_index   (out_fb_index),
    .out_pixel_word (out_pixel_word)
  );

endmodule
